// File: src/sm3_pkg.sv
// Shared types, constants and round functions of the SM3 hash block.
`timescale 1ns / 1ps
package sm3_pkg;

	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [31:0] T_LOW      = 32'h79cc4519;
	localparam logic [31:0] T_HIGH     = 32'h7a879d8a;
	localparam logic [31:0] PAD_ONE    = 32'h80000000;
	localparam logic [5:0]  FULL_BITS  = 6'd32;

	typedef enum logic [1:0] {
		K_DATA      = 2'd0,
		K_LAST_PART = 2'd1,
		K_LAST_FULL = 2'd2
	} sm3_kind_t;

	typedef struct packed {
		logic [31:0] word;
		logic [5:0]  bits;
		sm3_kind_t   kind;
	} sm3_entry_t;

	typedef struct packed {
		logic       valid;
		sm3_entry_t entry;
	} sm3_q_req_t;

	function automatic logic [31:0] iv_word(input logic [2:0] idx);
		logic [31:0] r;
		unique case (idx)
			3'd0: r = 32'h7380166f;
			3'd1: r = 32'h4914b2b9;
			3'd2: r = 32'h172442d7;
			3'd3: r = 32'hda8a0600;
			3'd4: r = 32'ha96f30bc;
			3'd5: r = 32'h163138aa;
			3'd6: r = 32'he38dee4d;
			default: r = 32'hb0fb0e4e;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
	endfunction

	// Round constant, rotated by the round number modulo 32.
	function automatic logic [31:0] t_rot(input logic [5:0] j);
		logic [31:0] base;
		base = (j[5:4] == 2'd0) ? T_LOW : T_HIGH;
		return rotl32(base, j[4:0]);
	endfunction

endpackage

// File: src/sm3_if.sv
// Valid/ready channel interfaces for message words and digest words.
`timescale 1ns / 1ps
interface sm3_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] message_word;
	logic [5:0]  word_bits;
	logic        last_word;

	modport source (output valid, message_word, word_bits, last_word, input ready);
	modport sink (input valid, message_word, word_bits, last_word, output ready);
endinterface

interface sm3_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_of_digest;

	modport source (output valid, digest_word, word_index, last_of_digest, input ready);
	modport sink (input valid, digest_word, word_index, last_of_digest, output ready);
endinterface

// File: src/sm3_hash_top.sv
// Top level of the SM3 hash block: front end, word queue and compression engine.
// A word is registered into the queue when accepted and is written into the block buffer
// once the engine is idle; each 16-word block is then compressed in 64 rounds, one round per
// cycle, and the engine pops no new word while it pads, compresses or sends the digest.
// A last word adds padding and one or two compressions, then 8 digest words.
// Reset clears the queue and control, and loads the initial chaining value at once.
`timescale 1ns / 1ps
module sm3_hash_top (
	input  logic     clk,
	input  logic     arst_n,
	sm3_in_if.sink   msg,
	sm3_out_if.source dig
);
	import sm3_pkg::*;

	sm3_q_req_t push;
	sm3_q_req_t head;
	logic       q_full;
	logic       q_pop;

	sm3_front u_front (
		.msg    (msg),
		.q_full (q_full),
		.push   (push)
	);

	sm3_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (q_pop)
	);

	sm3_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_head (head),
		.q_pop  (q_pop),
		.dig    (dig)
	);

endmodule

// File: src/sm3_front.sv
// Front end: takes message word requests, clamps the bit count and pre-pads partial last words.
`timescale 1ns / 1ps
module sm3_front (
	sm3_in_if.sink            msg,
	input  logic              q_full,
	output sm3_pkg::sm3_q_req_t push
);
	import sm3_pkg::*;

	logic [5:0]  bits_c;
	logic [31:0] keep;
	logic [31:0] one_bit;

	assign msg.ready = !q_full;

	always_comb begin
		bits_c  = (msg.word_bits > FULL_BITS) ? FULL_BITS : msg.word_bits;
		// both shifts see at most 31 here; a full last word takes the other branch
		keep    = ~(32'hffffffff >> bits_c[4:0]);
		one_bit = PAD_ONE >> bits_c[4:0];
		push.valid = msg.valid && !q_full;
		if (!msg.last_word) begin
			push.entry.word = msg.message_word;
			push.entry.bits = FULL_BITS;
			push.entry.kind = K_DATA;
		end else if (bits_c == FULL_BITS) begin
			push.entry.word = msg.message_word;
			push.entry.bits = FULL_BITS;
			push.entry.kind = K_LAST_FULL;
		end else begin
			push.entry.word = (msg.message_word & keep) | one_bit;
			push.entry.bits = bits_c;
			push.entry.kind = K_LAST_PART;
		end
	end

endmodule

// File: src/sm3_queue.sv
// Short queue of classified words between the front end and the compression engine.
`timescale 1ns / 1ps
module sm3_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  sm3_pkg::sm3_q_req_t push,
	output logic                full,
	output sm3_pkg::sm3_q_req_t head,
	input  logic                pop
);
	import sm3_pkg::*;

	sm3_entry_t           mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign full       = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.entry = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	function automatic logic [Q_PTR_W-1:0] ptr_next(input logic [Q_PTR_W-1:0] p);
		return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push.entry;
	end

	property p_no_pop_empty;
		@(posedge clk) disable iff (!arst_n) (cnt_q == '0) |-> !do_pop;
	endproperty
	a_no_pop_empty: assert property (p_no_pop_empty) else $error("pop from empty queue");

	property p_cnt_bound;
		@(posedge clk) disable iff (!arst_n) cnt_q <= Q_CNT_W'(Q_DEPTH);
	endproperty
	a_cnt_bound: assert property (p_cnt_bound) else $error("queue count overflow");

	property p_cnt_track;
		@(posedge clk) disable iff (!arst_n)
			(do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1);
	endproperty
	a_cnt_track: assert property (p_cnt_track) else $error("queue count lost a push");

endmodule

// File: src/sm3_back.sv
// Back end: fills the block, pads, runs one compression round per cycle and emits the digest.
`timescale 1ns / 1ps
module sm3_back (
	input  logic                clk,
	input  logic                arst_n,
	input  sm3_pkg::sm3_q_req_t q_head,
	output logic                q_pop,
	sm3_out_if.source           dig
);
	import sm3_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PAD  = 4'b0010,
		ST_COMP = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t       state_q;
	logic [3:0]   pos_q;
	logic [63:0]  len_q;
	logic [5:0]   round_q;
	logic [2:0]   out_idx_q;
	logic         padding_q;
	logic         pad_one_q;
	logic         hi_done_q;
	logic         final_q;
	logic [31:0]  cv_q [8];
	logic [31:0]  v_q  [8];
	logic [31:0]  w_q  [16];

	logic         wr_en;
	logic [31:0]  wr_data;
	logic [31:0]  pad_word;
	logic         pop_last;
	logic [31:0]  v_next [8];
	logic [31:0]  w_new;
	logic [31:0]  a12, ss1, ss2, ff, gg, tt1, tt2;

	assign pop_last = q_head.entry.kind != K_DATA;

	always_comb begin
		if (pad_one_q)                    pad_word = PAD_ONE;
		else if (pos_q == 4'd14)          pad_word = len_q[63:32];
		else if (pos_q == 4'd15 && hi_done_q) pad_word = len_q[31:0];
		else                              pad_word = '0;
		wr_en   = 1'b0;
		wr_data = '0;
		q_pop   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_head.valid) begin
					q_pop   = 1'b1;
					wr_en   = 1'b1;
					wr_data = q_head.entry.word;
				end
			end
			ST_PAD: begin
				wr_en   = 1'b1;
				wr_data = pad_word;
			end
			default: ;
		endcase
	end

	// One compression round and the next expanded word.
	always_comb begin
		a12 = rotl32(v_q[0], 5'd12);
		ss1 = rotl32(a12 + v_q[4] + t_rot(round_q), 5'd7);
		ss2 = ss1 ^ a12;
		if (round_q[5:4] == 2'd0) begin
			ff = v_q[0] ^ v_q[1] ^ v_q[2];
			gg = v_q[4] ^ v_q[5] ^ v_q[6];
		end else begin
			ff = (v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]);
			gg = (v_q[4] & v_q[5]) | (~v_q[4] & v_q[6]);
		end
		tt1 = ff + v_q[3] + ss2 + (w_q[0] ^ w_q[4]);
		tt2 = gg + v_q[7] + ss1 + w_q[0];
		v_next[0] = tt1;
		v_next[1] = v_q[0];
		v_next[2] = rotl32(v_q[1], 5'd9);
		v_next[3] = v_q[2];
		v_next[4] = perm0(tt2);
		v_next[5] = v_q[4];
		v_next[6] = rotl32(v_q[5], 5'd19);
		v_next[7] = v_q[6];
		w_new = perm1(w_q[0] ^ w_q[7] ^ rotl32(w_q[13], 5'd15))
			^ rotl32(w_q[3], 5'd7) ^ w_q[10];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			len_q     <= '0;
			round_q   <= '0;
			out_idx_q <= '0;
			padding_q <= 1'b0;
			pad_one_q <= 1'b0;
			hi_done_q <= 1'b0;
			final_q   <= 1'b0;
			for (int i = 0; i < 8; i++) cv_q[i] <= iv_word(3'(i));
		end else begin
			if (wr_en) begin
				pos_q <= pos_q + 1'b1;
				if (pos_q == 4'd15) begin
					state_q <= ST_COMP;
					round_q <= '0;
				end else if (state_q == ST_IDLE && pop_last) begin
					state_q <= ST_PAD;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						len_q <= len_q + {58'd0, q_head.entry.bits};
						if (pop_last) begin
							padding_q <= 1'b1;
							pad_one_q <= q_head.entry.kind == K_LAST_FULL;
						end
					end
				end
				ST_PAD: begin
					if (pad_one_q)                        pad_one_q <= 1'b0;
					else if (pos_q == 4'd14)              hi_done_q <= 1'b1;
					else if (pos_q == 4'd15 && hi_done_q) final_q   <= 1'b1;
				end
				ST_COMP: begin
					round_q <= round_q + 1'b1;
					if (round_q == 6'd63) begin
						for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] ^ v_next[i];
						if (final_q)        state_q <= ST_OUT;
						else if (padding_q) state_q <= ST_PAD;
						else                state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (dig.ready) begin
						out_idx_q <= out_idx_q + 1'b1;
						if (out_idx_q == 3'd7) begin
							// back to the initial value for the next message
							state_q   <= ST_IDLE;
							len_q     <= '0;
							padding_q <= 1'b0;
							hi_done_q <= 1'b0;
							final_q   <= 1'b0;
							for (int i = 0; i < 8; i++) cv_q[i] <= iv_word(3'(i));
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			w_q[pos_q] <= wr_data;
			if (pos_q == 4'd15) begin
				for (int i = 0; i < 8; i++) v_q[i] <= cv_q[i];
			end
		end
		if (state_q == ST_COMP) begin
			// slide the expansion window by one word
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= w_new;
			for (int i = 0; i < 8; i++) v_q[i] <= v_next[i];
		end
	end

	assign dig.valid          = (state_q == ST_OUT);
	assign dig.digest_word    = cv_q[out_idx_q];
	assign dig.word_index     = out_idx_q;
	assign dig.last_of_digest = (out_idx_q == 3'd7);

	property p_out_block_aligned;
		@(posedge clk) disable iff (!arst_n)
			(state_q == ST_OUT) |-> (pos_q == 4'd0 && final_q && !pad_one_q);
	endproperty
	a_out_block_aligned: assert property (p_out_block_aligned)
		else $error("digest out of a partly filled block");

	property p_comp_after_full;
		@(posedge clk) disable iff (!arst_n)
			(state_q == ST_COMP && round_q == 6'd0) |-> ($past(pos_q) == 4'd15);
	endproperty
	a_comp_after_full: assert property (p_comp_after_full)
		else $error("compression started without a full block");

	property p_pad_one_in_padding;
		@(posedge clk) disable iff (!arst_n) pad_one_q |-> padding_q;
	endproperty
	a_pad_one_in_padding: assert property (p_pad_one_in_padding)
		else $error("pending one bit outside padding");

	property p_final_after_hi;
		@(posedge clk) disable iff (!arst_n) final_q |-> hi_done_q;
	endproperty
	a_final_after_hi: assert property (p_final_after_hi)
		else $error("length low word before high word");

endmodule
